/* src/dkot_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dkot_pkg: shared types and codes of the keyed ordered table
// Entry layout, operation and status codes, and controller states.
// ----------------------------------------------------------------------------
package dkot_pkg;

  localparam int unsigned DepthDefault = 64;

  localparam logic [2:0] OP_PUT     = 3'd0;
  localparam logic [2:0] OP_REPLACE = 3'd1;
  localparam logic [2:0] OP_REMOVE  = 3'd2;
  localparam logic [2:0] OP_FIND    = 3'd3;
  localparam logic [2:0] OP_READ    = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [63:0] key;
    logic [31:0] payload;
    logic [31:0] label;
    logic [31:0] creator;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_READ,
    S_DECIDE,
    S_SHIFT,
    S_RESP
  } state_e;

endpackage
`default_nettype wire

/* src/dkot_mem.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dkot_mem: entry store of the keyed ordered table
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module dkot_mem import dkot_pkg::*; #(
  parameter int unsigned DEPTH = DepthDefault,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic          clk_i,
  input  wire logic          rd_en_i,
  input  wire logic [AW-1:0] rd_addr_i,
  output entry_t             rd_data_o,
  input  wire logic          wr_en_i,
  input  wire logic [AW-1:0] wr_addr_i,
  input  entry_t             wr_data_i
);

  entry_t mem_q [DEPTH];
  entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
`default_nettype wire

/* src/dedup_keyed_ordered_table.sv */
`timescale 1ns / 1ps
`default_nettype none
// Find and put scan the entries from position 0 upward until the key is found or the entry count is reached.
// Remove, and replace onto a clashing key, then shift the entries above the removed position P down one place.
// Read at a position reads that one entry from the entry memory. One operation is worked on at a time;
// the entry memory gives one entry per cycle to the key scan and to the shift.
// Reset clears the entry count and the control state only; the entry memory is not cleared,
// and entries are only read below the entry count.
// ----------------------------------------------------------------------------
// dedup_keyed_ordered_table: deduplicating keyed table in insertion order
// Sequencer that scans, rewrites and shifts entries held in dkot_mem.
// ----------------------------------------------------------------------------
module dedup_keyed_ordered_table import dkot_pkg::*; #(
  parameter int unsigned DEPTH = DepthDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  operation_i,
  input  wire logic [63:0] key_i,
  input  wire logic [63:0] new_key_i,
  input  wire logic [31:0] payload_i,
  input  wire logic [31:0] label_i,
  input  wire logic        label_valid_i,
  input  wire logic [31:0] creator_i,
  input  wire logic        creator_valid_i,
  input  wire logic [5:0]  position_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       status_o,
  output logic [5:0]       slot_o,
  output logic [63:0]      entry_key_o,
  output logic [31:0]      entry_payload_o,
  output logic [31:0]      entry_label_o,
  output logic [31:0]      entry_creator_o,
  output logic [6:0]       occupancy_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  state_e          state_q, state_d;
  logic [CW-1:0]   count_q, count_d;
  logic [CW-1:0]   issue_q, issue_d;
  logic            pend_q, pend_d;
  logic [AW-1:0]   pend_idx_q, pend_idx_d;
  logic            at_found_q, at_found_d;
  logic [AW-1:0]   at_idx_q, at_idx_d;
  entry_t          at_entry_q, at_entry_d;
  logic            cl_found_q, cl_found_d;
  logic [AW-1:0]   cl_idx_q, cl_idx_d;
  logic            at_f, cl_f;

  logic [2:0]      req_op_q, req_op_d;
  logic [63:0]     req_key_q, req_key_d;
  logic [63:0]     req_nkey_q, req_nkey_d;
  logic [31:0]     req_pay_q, req_pay_d;
  logic [31:0]     req_lab_q, req_lab_d;
  logic            req_lab_ok_q, req_lab_ok_d;
  logic [31:0]     req_cre_q, req_cre_d;
  logic            req_cre_ok_q, req_cre_ok_d;

  logic [1:0]      res_status_q, res_status_d;
  logic [5:0]      res_slot_q, res_slot_d;
  entry_t          res_entry_q, res_entry_d;

  logic            out_valid_q, out_valid_d;
  logic            out_load;
  logic [1:0]      out_status_q;
  logic [5:0]      out_slot_q;
  entry_t          out_entry_q;
  logic [6:0]      out_occ_q;

  logic            mem_re, mem_we;
  logic [AW-1:0]   mem_raddr, mem_waddr;
  entry_t          mem_wdata, mem_rdata;
  logic            pos_ok;

  dkot_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .rd_en_i   (mem_re),
    .rd_addr_i (mem_raddr),
    .rd_data_o (mem_rdata),
    .wr_en_i   (mem_we),
    .wr_addr_i (mem_waddr),
    .wr_data_i (mem_wdata)
  );

  assign pos_ok = (32'(position_i) < 32'(count_q)) && (32'(position_i) < DEPTH);
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    issue_d      = issue_q;
    pend_d       = pend_q;
    pend_idx_d   = pend_idx_q;
    at_found_d   = at_found_q;
    at_idx_d     = at_idx_q;
    at_entry_d   = at_entry_q;
    cl_found_d   = cl_found_q;
    cl_idx_d     = cl_idx_q;
    req_op_d     = req_op_q;
    req_key_d    = req_key_q;
    req_nkey_d   = req_nkey_q;
    req_pay_d    = req_pay_q;
    req_lab_d    = req_lab_q;
    req_lab_ok_d = req_lab_ok_q;
    req_cre_d    = req_cre_q;
    req_cre_ok_d = req_cre_ok_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    res_entry_d  = res_entry_q;
    out_load     = 1'b0;
    mem_re       = 1'b0;
    mem_raddr    = '0;
    mem_we       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = '0;
    at_f         = at_found_q;
    cl_f         = cl_found_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_op_d     = operation_i;
          req_key_d    = key_i;
          req_nkey_d   = new_key_i;
          req_pay_d    = payload_i;
          req_lab_d    = label_i;
          req_lab_ok_d = label_valid_i;
          req_cre_d    = creator_i;
          req_cre_ok_d = creator_valid_i;
          res_status_d = ST_MISS;
          res_slot_d   = '0;
          res_entry_d  = '0;
          at_found_d   = 1'b0;
          cl_found_d   = 1'b0;
          pend_d       = 1'b0;
          issue_d      = '0;
          case (operation_i) inside
            OP_PUT, OP_REPLACE, OP_REMOVE, OP_FIND: begin
              state_d = S_SCAN;
            end
            OP_READ: begin
              if (pos_ok) begin
                mem_re     = 1'b1;
                mem_raddr  = AW'(position_i);
                res_slot_d = position_i;
                state_d    = S_READ;
              end else begin
                state_d = S_RESP;
              end
            end
            default: begin
              state_d = S_RESP;
            end
          endcase
        end
      end

      S_SCAN: begin
        // Compare the entry read last cycle against both keys; the first hit of each is kept.
        if (pend_q) begin
          if (!at_found_q && (mem_rdata.key == req_key_q)) begin
            at_found_d = 1'b1;
            at_idx_d   = pend_idx_q;
            at_entry_d = mem_rdata;
            at_f       = 1'b1;
          end
          if (!cl_found_q && (mem_rdata.key == req_nkey_q)) begin
            cl_found_d = 1'b1;
            cl_idx_d   = pend_idx_q;
            cl_f       = 1'b1;
          end
        end
        if ((at_f && ((req_op_q != OP_REPLACE) || cl_f)) ||
            (!pend_q && (issue_q >= count_q))) begin
          pend_d  = 1'b0;
          state_d = S_DECIDE;
        end else if (issue_q < count_q) begin
          mem_re     = 1'b1;
          mem_raddr  = AW'(issue_q);
          pend_d     = 1'b1;
          pend_idx_d = AW'(issue_q);
          issue_d    = issue_q + CW'(1);
        end else begin
          pend_d = 1'b0;
        end
      end

      S_READ: begin
        res_entry_d  = mem_rdata;
        res_status_d = ST_OK;
        state_d      = S_RESP;
      end

      S_DECIDE: begin
        state_d = S_RESP;
        pend_d  = 1'b0;
        issue_d = CW'(at_idx_q) + CW'(1);
        case (req_op_q)
          OP_PUT: begin
            if (at_found_q) begin
              mem_we            = 1'b1;
              mem_waddr         = at_idx_q;
              mem_wdata         = at_entry_q;
              mem_wdata.label   = req_lab_ok_q ? req_lab_q : at_entry_q.label;
              mem_wdata.creator = req_cre_ok_q ? req_cre_q : at_entry_q.creator;
              res_status_d      = ST_OK;
              res_slot_d        = 6'(at_idx_q);
            end else if (32'(count_q) >= DEPTH) begin
              res_status_d = ST_FULL;
            end else begin
              mem_we            = 1'b1;
              mem_waddr         = AW'(count_q);
              mem_wdata.key     = req_key_q;
              mem_wdata.payload = req_pay_q;
              mem_wdata.label   = req_lab_ok_q ? req_lab_q : 32'd0;
              mem_wdata.creator = req_cre_ok_q ? req_cre_q : 32'd0;
              res_status_d      = ST_OK;
              res_slot_d        = 6'(count_q);
              count_d           = count_q + CW'(1);
            end
          end
          OP_REPLACE: begin
            if (at_found_q) begin
              res_status_d = ST_OK;
              if (cl_found_q && (cl_idx_q != at_idx_q)) begin
                // The clashing entry moves down by one if it lies above the removed one.
                res_slot_d = (cl_idx_q > at_idx_q) ? 6'(cl_idx_q - AW'(1)) : 6'(cl_idx_q);
                state_d    = S_SHIFT;
              end else begin
                mem_we            = 1'b1;
                mem_waddr         = at_idx_q;
                mem_wdata         = at_entry_q;
                mem_wdata.key     = req_nkey_q;
                mem_wdata.payload = req_pay_q;
                res_slot_d        = 6'(at_idx_q);
              end
            end
          end
          OP_REMOVE: begin
            if (at_found_q) begin
              res_status_d = ST_OK;
              res_slot_d   = 6'(at_idx_q);
              state_d      = S_SHIFT;
            end
          end
          OP_FIND: begin
            if (at_found_q) begin
              res_status_d = ST_OK;
              res_slot_d   = 6'(at_idx_q);
            end
          end
          default: begin
          end
        endcase
      end

      S_SHIFT: begin
        // Each entry read from above the gap is written one place down in the following cycle.
        if (pend_q) begin
          mem_we    = 1'b1;
          mem_waddr = pend_idx_q - AW'(1);
          mem_wdata = mem_rdata;
        end
        if (issue_q < count_q) begin
          mem_re     = 1'b1;
          mem_raddr  = AW'(issue_q);
          pend_d     = 1'b1;
          pend_idx_d = AW'(issue_q);
          issue_d    = issue_q + CW'(1);
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            count_d = count_q - CW'(1);
            state_d = S_RESP;
          end
        end
      end

      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = (out_valid_q && !out_ready_i) || out_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      issue_q     <= '0;
      pend_q      <= 1'b0;
      at_found_q  <= 1'b0;
      cl_found_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      issue_q     <= issue_d;
      pend_q      <= pend_d;
      at_found_q  <= at_found_d;
      cl_found_q  <= cl_found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_idx_q   <= pend_idx_d;
    at_idx_q     <= at_idx_d;
    at_entry_q   <= at_entry_d;
    cl_idx_q     <= cl_idx_d;
    req_op_q     <= req_op_d;
    req_key_q    <= req_key_d;
    req_nkey_q   <= req_nkey_d;
    req_pay_q    <= req_pay_d;
    req_lab_q    <= req_lab_d;
    req_lab_ok_q <= req_lab_ok_d;
    req_cre_q    <= req_cre_d;
    req_cre_ok_q <= req_cre_ok_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    res_entry_q  <= res_entry_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_slot_q   <= res_slot_q;
      out_entry_q  <= res_entry_q;
      out_occ_q    <= 7'(count_q);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign slot_o          = out_slot_q;
  assign entry_key_o     = out_entry_q.key;
  assign entry_payload_o = out_entry_q.payload;
  assign entry_label_o   = out_entry_q.label;
  assign entry_creator_o = out_entry_q.creator;
  assign occupancy_o     = out_occ_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= DEPTH)
    else $error("entry count above table depth");

  a_idle_no_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ready_o || state_q == S_RESP) |-> !mem_we)
    else $error("memory written while no operation is in progress");

  a_shift_no_overlap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_re && mem_we) |-> (mem_raddr != mem_waddr))
    else $error("read and write of the same entry in one cycle");

  a_count_change : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |->
      ($past(state_q) == S_DECIDE || $past(state_q) == S_SHIFT))
    else $error("entry count changed outside append or shift");

endmodule
`default_nettype wire
